// File: design/cbts_pkg.sv
// cbts_pkg: shared constants for the can bit timing search block
// register indexes, field widths and fixed arithmetic constants
// no dependencies
package cbts_pkg;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_INPUT_CLOCK = 2'd0;
  localparam logic [1:0] REG_SAMPLE_PT   = 2'd1;
  localparam logic [1:0] REG_JUMP_WIDTH  = 2'd2;
  localparam logic [1:0] REG_EXACT_RATE  = 2'd3;

  // field widths
  localparam int CLK_W    = 30;
  localparam int SP_W     = 7;
  localparam int JW_W     = 3;
  localparam int RATE_W   = 20;
  localparam int PRESC_FW = 10;
  localparam int SEG1_FW  = 4;
  localparam int SEG2_FW  = 3;

  // reset values of the configuration registers
  localparam logic [CLK_W-1:0] CLK_RESET = 30'd12000000;
  localparam logic [SP_W-1:0]  SP_RESET  = 7'd75;
  localparam logic [JW_W-1:0]  JW_RESET  = 3'd1;

  // percent scale and the reciprocal used for x / 100 on products below 2^14
  localparam int PCT_SCALE   = 100;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;

endpackage

// File: design/can_bit_timing_search_top.sv
// can_bit_timing_search_top: bit timing search over quanta-per-bit widths
// depends on cbts_pkg; single module with a bit-serial divider pair
//
// usage:
//   configuration goes through the apb-style port (four 32-bit registers at
//   byte addresses 0, 4, 8, 12: input clock, sample point, jump width, exact
//   rate); write only while the block is idle.
//   the slave stream takes one requested bit rate per transaction in
//   s_tdata[19:0]; the master stream returns one result per request with
//   m_tuser = found and the prescaler and segment fields in m_tdata.
//   each width runs a multiply, a reciprocal step, a load, a 30-step restoring
//   divide of the input clock by the quantum clock (the sample point divide runs
//   beside it on a second serial unit) and an evaluation step.
//   a full search runs over the default 22 widths and stops early on an exact
//   match; a zero bit rate skips the search.
//   one request is worked on at a time; a new request is taken as soon as
//   the search ends, even while the last result still waits in the output
//   register. a stalled receiver holds the finished search until the output
//   register frees up.
//   reset (synchronous, active high) restores the register defaults and
//   drops any search and pending result.
module can_bit_timing_search_top
  import cbts_pkg::*;
#(
  parameter int SEG_ONE_MIN     = 1,
  parameter int SEG_ONE_MAX     = 15,
  parameter int SEG_TWO_MAX     = 7,
  parameter int PRESCALER_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] bit_rate, rest zero
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [9:0] prescaler_minus_one, [13:10] phase_one_field,
                                 // [16:14] phase_two_field, rest zero
  output logic        m_tuser    // [0] found
);

  localparam int WIDTH_TOP    = SEG_ONE_MAX + SEG_TWO_MAX + 3;
  localparam int WIDTH_BOTTOM = SEG_ONE_MIN + 3;
  localparam int WB           = $clog2(WIDTH_TOP + 1);
  localparam int QW           = RATE_W + WB;        // quantum clock width
  localparam int PROD_W       = WB + SP_W;          // width * sample point
  localparam int Q100_W       = WB + 1;             // (width * sample point) / 100
  localparam int SDIV_W       = Q100_W + SP_W;      // (s1 + 1) * 100
  localparam int DCNT_W       = $clog2(CLK_W + 1);
  localparam int SCNT_W       = $clog2(SDIV_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RECIP,
    ST_LOAD,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [CLK_W-1:0] input_clock_hz;
  logic [SP_W-1:0]  sample_point_percent;
  logic [JW_W-1:0]  jump_width;
  logic             exact_rate;

  // search registers
  logic [RATE_W-1:0]   rate;
  logic [WB-1:0]       width;
  logic [QW-1:0]       qclk;
  logic [PROD_W-1:0]   sp_prod;
  logic [Q100_W-1:0]   q100;

  // main serial divider: input clock / quantum clock
  logic [CLK_W-1:0]    div_quo;
  logic [QW-1:0]       div_rem;
  logic [DCNT_W-1:0]   div_cnt;

  // small serial divider: (s1 + 1) * 100 / width
  logic [SDIV_W-1:0]   sdiv_quo;
  logic [WB-1:0]       sdiv_rem;
  logic [SCNT_W-1:0]   sdiv_cnt;

  // best candidate
  logic                best_found;
  logic                best_err_open;
  logic [QW-1:0]       best_err;
  logic [SDIV_W-1:0]   best_delta;
  logic [PRESC_FW-1:0] best_presc;
  logic [SEG1_FW-1:0]  best_seg1;
  logic [SEG2_FW-1:0]  best_seg2;

  // output register fields
  logic                out_found;
  logic [PRESC_FW-1:0] out_presc;
  logic [SEG1_FW-1:0]  out_seg1;
  logic [SEG2_FW-1:0]  out_seg2;

  // apb write strobe
  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_clock_hz       <= CLK_RESET;
      sample_point_percent <= SP_RESET;
      jump_width           <= JW_RESET;
      exact_rate           <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_INPUT_CLOCK: input_clock_hz       <= pwdata[CLK_W-1:0];
        REG_SAMPLE_PT:   sample_point_percent <= pwdata[SP_W-1:0];
        REG_JUMP_WIDTH:  jump_width           <= pwdata[JW_W-1:0];
        REG_EXACT_RATE:  exact_rate           <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_INPUT_CLOCK: prdata = {{(32-CLK_W){1'b0}}, input_clock_hz};
      REG_SAMPLE_PT:   prdata = {{(32-SP_W){1'b0}}, sample_point_percent};
      REG_JUMP_WIDTH:  prdata = {{(32-JW_W){1'b0}}, jump_width};
      REG_EXACT_RATE:  prdata = {31'd0, exact_rate};
      default:         prdata = 32'd0;
    endcase
  end

  // main divider step: shift in the next dividend bit, subtract when it fits
  logic [QW:0] div_trial;
  logic        div_fit;
  assign div_trial = {div_rem, div_quo[CLK_W-1]};
  assign div_fit   = div_trial >= {1'b0, qclk};

  // small divider step
  logic [WB:0] sdiv_trial;
  logic        sdiv_fit;
  assign sdiv_trial = {sdiv_rem, sdiv_quo[SDIV_W-1]};
  assign sdiv_fit   = sdiv_trial >= {1'b0, width};

  // reciprocal product for the divide by 100
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  assign recip_prod = PROD_W'(sp_prod) * (PROD_W+RECIP_W)'(RECIP_100);

  // candidate evaluation
  logic [WB:0]         seg2_len;
  logic                split_ok;
  logic                err_ok;
  logic                presc_ok;
  logic [SDIV_W-1:0]   sp_ext;
  logic [SDIV_W-1:0]   delta;
  logic                take;
  logic                exact_hit;

  assign seg2_len = {1'b0, width} - {1'b0, q100[WB-1:0]};
  assign split_ok = (q100 >= Q100_W'(SEG_ONE_MIN + 2)) &&
                    (q100 <= Q100_W'(SEG_ONE_MAX + 2)) &&
                    ({1'b0, width} > q100) &&
                    (seg2_len > (WB+1)'(jump_width)) &&
                    (seg2_len <= (WB+1)'(SEG_TWO_MAX + 1)) &&
                    (seg2_len <= q100);
  assign err_ok   = best_err_open || (div_rem <= best_err);
  assign presc_ok = (div_quo != '0) && (div_quo <= CLK_W'(PRESCALER_LIMIT));
  assign sp_ext   = SDIV_W'(sample_point_percent);
  assign delta    = (sp_ext >= sdiv_quo) ? (sp_ext - sdiv_quo) : (sdiv_quo - sp_ext);
  assign take     = err_ok && presc_ok && split_ok &&
                    (!best_found || (div_rem < best_err) || (delta < best_delta));
  assign exact_hit = (div_rem == '0) && (delta == '0);

  assign s_tready = (state == ST_IDLE);

  // finished search moves into the output register
  logic out_load;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // search sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            rate          <= s_tdata[RATE_W-1:0];
            width         <= WB'(WIDTH_TOP);
            best_found    <= 1'b0;
            best_err_open <= !exact_rate;
            best_err      <= '0;
            best_delta    <= '0;
            best_presc    <= '0;
            best_seg1     <= '0;
            best_seg2     <= '0;
            state         <= (s_tdata[RATE_W-1:0] == '0) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          qclk    <= QW'(rate) * QW'(width);
          sp_prod <= PROD_W'(width) * PROD_W'(sample_point_percent);
          state   <= ST_RECIP;
        end
        ST_RECIP: begin
          q100  <= recip_prod[RECIP_SHIFT +: Q100_W];
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          div_quo  <= input_clock_hz;
          div_rem  <= '0;
          div_cnt  <= DCNT_W'(CLK_W);
          sdiv_quo <= SDIV_W'(q100) * SDIV_W'(PCT_SCALE);
          sdiv_rem <= '0;
          sdiv_cnt <= SCNT_W'(SDIV_W);
          state    <= ST_DIV;
        end
        ST_DIV: begin
          div_quo <= {div_quo[CLK_W-2:0], div_fit};
          div_rem <= div_fit ? QW'(div_trial - {1'b0, qclk}) : div_trial[QW-1:0];
          div_cnt <= div_cnt - 1'b1;
          if (sdiv_cnt != '0) begin
            sdiv_quo <= {sdiv_quo[SDIV_W-2:0], sdiv_fit};
            sdiv_rem <= sdiv_fit ? WB'(sdiv_trial - {1'b0, width}) : sdiv_trial[WB-1:0];
            sdiv_cnt <= sdiv_cnt - 1'b1;
          end
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (take) begin
            best_found    <= 1'b1;
            best_err_open <= 1'b0;
            best_err      <= div_rem;
            best_delta    <= delta;
            best_presc    <= PRESC_FW'(div_quo - 1'b1);
            best_seg1     <= SEG1_FW'(q100 - Q100_W'(2));
            best_seg2     <= SEG2_FW'(seg2_len - 1'b1);
          end
          if ((take && exact_hit) || (width == WB'(WIDTH_BOTTOM))) begin
            state <= ST_DONE;
          end else begin
            width <= width - 1'b1;
            state <= ST_MUL;
          end
        end
        ST_DONE: begin
          // wait for the output register to free up
          if (out_load) begin
            m_tvalid  <= 1'b1;
            out_found <= best_found;
            out_presc <= best_found ? best_presc : '0;
            out_seg1  <= best_found ? best_seg1 : '0;
            out_seg2  <= best_found ? best_seg2 : '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tuser = out_found;
  assign m_tdata = {{(24-PRESC_FW-SEG1_FW-SEG2_FW){1'b0}}, out_seg2, out_seg1, out_presc};

  // a result with nothing found carries all-zero fields
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("not-found result carries nonzero fields");

  // a found timing keeps segment two longer than the jump width and no longer than segment one plus one
  a_found_segments: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      ({1'b0, out_seg2} + 4'd1 > {1'b0, jump_width}) &&
      ({1'b0, out_seg2} <= {2'b0, out_seg1} + 5'd1))
    else $error("found result breaks segment limits");

  // a new result only appears straight out of the finishing state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the finishing state");

endmodule
